>>> design/apt_pkg.sv
// shared types and codes for the actuator position tracker
`default_nettype none

package apt_pkg;

    // item function codes
    localparam logic [1:0] FUNC_SAMPLE   = 2'd0;
    localparam logic [1:0] FUNC_EXTEND   = 2'd1;
    localparam logic [1:0] FUNC_CONTRACT = 2'd2;
    localparam logic [1:0] FUNC_STOP     = 2'd3;

    // motion codes
    localparam logic [1:0] MOT_STOP     = 2'd0;
    localparam logic [1:0] MOT_EXTEND   = 2'd1;
    localparam logic [1:0] MOT_CONTRACT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ENCODER_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_LEVEL_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_MAX_POSITION    = 2'd2;
    localparam logic [1:0] CFG_QUIET_LIMIT     = 2'd3;

    localparam int CFG_DATA_W = 16;
    localparam int SAMPLE_W   = 10;
    localparam int POS_W      = 16;

    // reset values of the configuration registers
    localparam logic                RST_ENCODER_ENABLE  = 1'b1;
    localparam logic [SAMPLE_W-1:0] RST_LEVEL_THRESHOLD = 10'd512;
    localparam logic [POS_W-1:0]    RST_MAX_POSITION    = 16'd1000;
    localparam logic [POS_W-1:0]    RST_QUIET_LIMIT     = 16'd100;

    typedef struct packed {
        logic                encoder_enable;
        logic [SAMPLE_W-1:0] level_threshold;
        logic [POS_W-1:0]    max_position;
        logic [POS_W-1:0]    quiet_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]       direction;
        logic             accepted;
        logic [POS_W-1:0] position;
    } t_result;

endpackage

`default_nettype wire

>>> design/apt_cfg_regs.sv
// configuration register bank of the actuator position tracker
`default_nettype none

module apt_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [1:0]                     i_cfg_index,
    input  wire logic [apt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output apt_pkg::t_cfg                       o_cfg
);

    apt_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.encoder_enable  <= apt_pkg::RST_ENCODER_ENABLE;
            r_cfg.level_threshold <= apt_pkg::RST_LEVEL_THRESHOLD;
            r_cfg.max_position    <= apt_pkg::RST_MAX_POSITION;
            r_cfg.quiet_limit     <= apt_pkg::RST_QUIET_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                apt_pkg::CFG_ENCODER_ENABLE: begin
                    r_cfg.encoder_enable <= i_cfg_data[0];
                end
                apt_pkg::CFG_LEVEL_THRESHOLD: begin
                    r_cfg.level_threshold <= i_cfg_data[apt_pkg::SAMPLE_W-1:0];
                end
                apt_pkg::CFG_MAX_POSITION: begin
                    r_cfg.max_position <= i_cfg_data[apt_pkg::POS_W-1:0];
                end
                apt_pkg::CFG_QUIET_LIMIT: begin
                    r_cfg.quiet_limit <= i_cfg_data[apt_pkg::POS_W-1:0];
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> design/apt_core.sv
// tracker state and the single-pass update for one item
`default_nettype none

module apt_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_fire,
    input  wire logic [1:0]                   i_func,
    input  wire logic [apt_pkg::SAMPLE_W-1:0] i_sample,
    input  wire apt_pkg::t_cfg                i_cfg,
    output apt_pkg::t_result                  o_result
);

    logic [1:0]                r_motion;
    logic [apt_pkg::POS_W-1:0] r_position;
    logic                      r_last_level;
    logic [apt_pkg::POS_W-1:0] r_quiet_count;

    logic [1:0]                n_motion;
    logic [apt_pkg::POS_W-1:0] n_position;
    logic                      n_last_level;
    logic [apt_pkg::POS_W-1:0] n_quiet_count;
    logic                      w_ok;
    logic                      w_level;
    logic                      w_edge;
    logic                      w_below_max;
    logic                      w_above_zero;

    assign w_level      = (i_sample > i_cfg.level_threshold);
    assign w_edge       = (w_level != r_last_level) || (r_quiet_count >= i_cfg.quiet_limit);
    assign w_below_max  = (r_position < i_cfg.max_position);
    assign w_above_zero = (r_position != '0);

    always_comb begin
        n_motion      = r_motion;
        n_position    = r_position;
        n_last_level  = r_last_level;
        n_quiet_count = r_quiet_count;
        w_ok          = 1'b0;
        unique case (i_func)
            apt_pkg::FUNC_SAMPLE: begin
                if (i_cfg.encoder_enable) begin
                    w_ok         = 1'b1;
                    n_last_level = w_level;
                    if (w_edge) begin
                        if (r_motion == apt_pkg::MOT_EXTEND && w_below_max) begin
                            n_position = r_position + 1'b1;
                        end else if (r_motion == apt_pkg::MOT_CONTRACT && w_above_zero) begin
                            n_position = r_position - 1'b1;
                        end
                        n_quiet_count = '0;
                    end else if (r_quiet_count != '1) begin
                        n_quiet_count = r_quiet_count + 1'b1;
                    end
                end
            end
            apt_pkg::FUNC_EXTEND: begin
                if (!i_cfg.encoder_enable || w_below_max) begin
                    n_motion = apt_pkg::MOT_EXTEND;
                    w_ok     = 1'b1;
                end
            end
            apt_pkg::FUNC_CONTRACT: begin
                if (!i_cfg.encoder_enable || w_above_zero) begin
                    n_motion = apt_pkg::MOT_CONTRACT;
                    w_ok     = 1'b1;
                end
            end
            apt_pkg::FUNC_STOP: begin
                n_motion = apt_pkg::MOT_STOP;
                w_ok     = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion      <= apt_pkg::MOT_STOP;
            r_position    <= '0;
            r_last_level  <= 1'b0;
            r_quiet_count <= '0;
        end else if (i_fire) begin
            r_motion      <= n_motion;
            r_position    <= n_position;
            r_last_level  <= n_last_level;
            r_quiet_count <= n_quiet_count;
        end
    end

    assign o_result.direction = n_motion;
    assign o_result.accepted  = w_ok;
    assign o_result.position  = n_position;

endmodule

`default_nettype wire

>>> design/actuator_position_tracker_top.sv
// Linear actuator position tracker. Takes one item per clock while the input is not
// stalled (encoder sample or extend, contract, stop command) and returns one result per
// item: the item is registered, passes the threshold compare and saturating counter
// update, and lands in the result register. Throughput is one item per cycle when the
// output is not stalled, set by that single update of the motion, position, level and
// quiet counter registers; while a result waits, the input register takes one more item
// and then stalls the input until the result is taken.
// Configuration writes (index 0 encoder enable, 1 level threshold, 2 max position,
// 3 quiet limit) take effect at once and belong in idle periods only.
`default_nettype none

module actuator_position_tracker_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [1:0]                     i_cfg_index,
    input  wire logic [apt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output      logic                           o_in_stall,
    input  wire logic [1:0]                     i_func,
    input  wire logic [apt_pkg::SAMPLE_W-1:0]   i_sample,
    output      logic                           o_out_valid,
    input  wire logic                           i_out_stall,
    output      logic [1:0]                     o_direction,
    output      logic                           o_accepted,
    output      logic [apt_pkg::POS_W-1:0]      o_position,
    output      logic                           o_drive_extend,
    output      logic                           o_drive_contract
);

    apt_pkg::t_cfg    w_cfg;
    apt_pkg::t_result w_result;

    logic                         r_in_valid;
    logic [1:0]                   r_func;
    logic [apt_pkg::SAMPLE_W-1:0] r_sample;
    logic                         r_out_valid;
    apt_pkg::t_result             r_result;

    logic w_advance;
    logic w_in_fire;

    // result slot frees when empty or when its item is taken this cycle
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_fire  = i_in_valid && !o_in_stall;

    apt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    apt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_func   (r_func),
        .i_sample (r_sample),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_func   <= i_func;
            r_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_direction      = r_result.direction;
    assign o_accepted       = r_result.accepted;
    assign o_position       = r_result.position;
    assign o_drive_extend   = (r_result.direction == apt_pkg::MOT_EXTEND);
    assign o_drive_contract = (r_result.direction == apt_pkg::MOT_CONTRACT);

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |-> !w_in_fire)
        else $error("input register overwritten while its item is held");

    a_drive_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_drive_extend && o_drive_contract))
        else $error("both motor directions driven");

    a_direction_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_direction != 2'd3))
        else $error("invalid motion code on result");

    a_stop_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_func == apt_pkg::FUNC_STOP) |=>
        (o_accepted && o_direction == apt_pkg::MOT_STOP))
        else $error("stop item not carried out");

endmodule

`default_nettype wire

>>> verif/tb.sv
// testbench for the actuator position tracker: random and directed items checked against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef logic [apt_pkg::SAMPLE_W-1:0] t_sample;

    typedef struct {
        logic [1:0]                   func;
        logic [apt_pkg::SAMPLE_W-1:0] sample;
        bit                           drain;
    } t_item;

    typedef struct packed {
        logic [1:0]                direction;
        logic                      accepted;
        logic [apt_pkg::POS_W-1:0] position;
        logic                      drive_extend;
        logic                      drive_contract;
    } t_tracker_out;

    logic                           i_clk            = 1'b0;
    logic                           i_rst_n          = 1'b0;
    logic                           i_cfg_we         = 1'b0;
    logic [1:0]                     i_cfg_index      = apt_pkg::CFG_ENCODER_ENABLE;
    logic [apt_pkg::CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                           i_in_valid       = 1'b0;
    logic                           o_in_stall;
    logic [1:0]                     i_func           = apt_pkg::FUNC_SAMPLE;
    logic [apt_pkg::SAMPLE_W-1:0]   i_sample         = '0;
    logic                           o_out_valid;
    logic                           i_out_stall      = 1'b0;
    logic [1:0]                     o_direction;
    logic                           o_accepted;
    logic [apt_pkg::POS_W-1:0]      o_position;
    logic                           o_drive_extend;
    logic                           o_drive_contract;

    // predictor copy of configuration and tracker state
    logic                         cfg_enc    = apt_pkg::RST_ENCODER_ENABLE;
    logic [apt_pkg::SAMPLE_W-1:0] cfg_thr    = apt_pkg::RST_LEVEL_THRESHOLD;
    logic [apt_pkg::POS_W-1:0]    cfg_max    = apt_pkg::RST_MAX_POSITION;
    logic [apt_pkg::POS_W-1:0]    cfg_quiet  = apt_pkg::RST_QUIET_LIMIT;
    logic [1:0]                   trk_motion = apt_pkg::MOT_STOP;
    logic [apt_pkg::POS_W-1:0]    trk_pos    = '0;
    logic                         trk_level  = 1'b0;
    logic [apt_pkg::POS_W-1:0]    trk_quiet  = '0;

    t_item        pending_items[$];
    t_tracker_out expected_results[$];
    int           in_count      = 0;
    int           out_count     = 0;
    int           fail_count    = 0;
    int           send_idle_pct = 33;
    int           recv_stall_pct = 59;
    int           stall_cycles  = 0;
    logic         gen_level     = 1'b0;

    actuator_position_tracker_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_sample        (i_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_direction     (o_direction),
        .o_accepted      (o_accepted),
        .o_position      (o_position),
        .o_drive_extend  (o_drive_extend),
        .o_drive_contract(o_drive_contract)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_tracker_out track_item(logic [1:0] f,
                                                logic [apt_pkg::SAMPLE_W-1:0] s);
        t_tracker_out r;
        logic         lvl;
        logic         ok;
        ok = 1'b0;
        case (f)
            apt_pkg::FUNC_SAMPLE: begin
                if (cfg_enc) begin
                    lvl = (s > cfg_thr);
                    if (lvl != trk_level || trk_quiet >= cfg_quiet) begin
                        if (trk_motion == apt_pkg::MOT_EXTEND && trk_pos < cfg_max)
                            trk_pos = trk_pos + 1'b1;
                        else if (trk_motion == apt_pkg::MOT_CONTRACT && trk_pos != '0)
                            trk_pos = trk_pos - 1'b1;
                        trk_quiet = '0;
                    end else if (trk_quiet != '1) begin
                        trk_quiet = trk_quiet + 1'b1;
                    end
                    trk_level = lvl;
                    ok = 1'b1;
                end
            end
            apt_pkg::FUNC_EXTEND: begin
                if (!cfg_enc || trk_pos < cfg_max) begin
                    trk_motion = apt_pkg::MOT_EXTEND;
                    ok = 1'b1;
                end
            end
            apt_pkg::FUNC_CONTRACT: begin
                if (!cfg_enc || trk_pos != '0) begin
                    trk_motion = apt_pkg::MOT_CONTRACT;
                    ok = 1'b1;
                end
            end
            default: begin
                trk_motion = apt_pkg::MOT_STOP;
                ok = 1'b1;
            end
        endcase
        r.direction      = trk_motion;
        r.accepted       = ok;
        r.position       = trk_pos;
        r.drive_extend   = (trk_motion == apt_pkg::MOT_EXTEND);
        r.drive_contract = (trk_motion == apt_pkg::MOT_CONTRACT);
        return r;
    endfunction

    // driver: presents queued items, holds a stalled item, predicts on acceptance
    always @(posedge i_clk) begin : drive_items
        t_item nxt;
        logic  take;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            take = i_in_valid && !o_in_stall;
            if (take) begin
                expected_results.push_back(track_item(i_func, i_sample));
                in_count <= in_count + 1;
            end
            if (!i_in_valid || take) begin
                // a drain item waits until every result so far has come out
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct &&
                    (!pending_items[0].drain || (!take && in_count == out_count))) begin
                    nxt = pending_items.pop_front();
                    i_in_valid <= 1'b1;
                    i_func     <= nxt.func;
                    i_sample   <= nxt.sample;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back pressure and in-order compare
    always @(posedge i_clk) begin : check_results
        t_tracker_out exp_r;
        t_tracker_out got_r;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            if (o_out_valid && !i_out_stall) begin
                out_count <= out_count + 1;
                got_r = {o_direction, o_accepted, o_position, o_drive_extend, o_drive_contract};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected item dir %0d acc %0d pos %0d ext %0d con %0d",
                             $time, got_r.direction, got_r.accepted, got_r.position,
                             got_r.drive_extend, got_r.drive_contract);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got_r !== exp_r) begin
                        $display("%0t: expected dir %0d acc %0d pos %0d ext %0d con %0d",
                                 $time, exp_r.direction, exp_r.accepted, exp_r.position,
                                 exp_r.drive_extend, exp_r.drive_contract);
                        $display("%0t: actual   dir %0d acc %0d pos %0d ext %0d con %0d",
                                 $time, got_r.direction, got_r.accepted, got_r.position,
                                 got_r.drive_extend, got_r.drive_contract);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic void queue_item(logic [1:0] f, logic [apt_pkg::SAMPLE_W-1:0] s);
        t_item it;
        it.func   = f;
        it.sample = s;
        it.drain  = 1'b0;
        pending_items.push_back(it);
    endfunction

    // mostly samples that flip level around the threshold
    function automatic logic [apt_pkg::SAMPLE_W-1:0] pick_sample();
        logic lvl;
        if ($urandom_range(99) < 30)
            return t_sample'($urandom_range(1023));
        lvl = ($urandom_range(99) < 70) ? ~gen_level : gen_level;
        gen_level = lvl;
        if (lvl && cfg_thr != '1)
            return t_sample'($urandom_range(1023, int'(cfg_thr) + 1));
        else if (!lvl)
            return t_sample'($urandom_range(int'(cfg_thr), 0));
        return t_sample'($urandom_range(1023));
    endfunction

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || in_count != out_count);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_cfg(logic en, logic [apt_pkg::SAMPLE_W-1:0] thr,
                           logic [apt_pkg::POS_W-1:0] maxp, logic [apt_pkg::POS_W-1:0] ql);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= apt_pkg::CFG_ENCODER_ENABLE;
        i_cfg_data  <= {{(apt_pkg::CFG_DATA_W-1){1'b0}}, en};
        @(posedge i_clk);
        i_cfg_index <= apt_pkg::CFG_LEVEL_THRESHOLD;
        i_cfg_data  <= {{(apt_pkg::CFG_DATA_W-apt_pkg::SAMPLE_W){1'b0}}, thr};
        @(posedge i_clk);
        i_cfg_index <= apt_pkg::CFG_MAX_POSITION;
        i_cfg_data  <= maxp;
        @(posedge i_clk);
        i_cfg_index <= apt_pkg::CFG_QUIET_LIMIT;
        i_cfg_data  <= ql;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        cfg_enc   = en;
        cfg_thr   = thr;
        cfg_max   = maxp;
        cfg_quiet = ql;
        @(negedge i_clk);
    endtask

    // command followed by a run of samples, with some stray items mixed in
    task automatic run_segment(logic en, logic [apt_pkg::SAMPLE_W-1:0] thr,
                               logic [apt_pkg::POS_W-1:0] maxp,
                               logic [apt_pkg::POS_W-1:0] ql, int ext_pct, int send_pct,
                               int recv_pct);
        int         cnt;
        int         r;
        int         run_len;
        logic [1:0] cmd;
        set_cfg(en, thr, maxp, ql);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        cnt = 0;
        while (cnt < 190) begin
            if ($urandom_range(99) < 10) begin
                queue_item(2'($urandom_range(3)), t_sample'($urandom_range(1023)));
                cnt++;
            end else begin
                r = $urandom_range(99);
                cmd = (r < ext_pct) ? apt_pkg::FUNC_EXTEND :
                      (r < 85) ? apt_pkg::FUNC_CONTRACT : apt_pkg::FUNC_STOP;
                queue_item(cmd, t_sample'($urandom_range(1023)));
                run_len = $urandom_range(12, 1);
                repeat (run_len) queue_item(apt_pkg::FUNC_SAMPLE, pick_sample());
                cnt += run_len + 1;
            end
        end
        pending_items[pending_items.size() / 2].drain = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset configuration: refusals at zero, level edges, saturation at zero
        queue_item(apt_pkg::FUNC_CONTRACT, 10'd1023);
        queue_item(apt_pkg::FUNC_SAMPLE, 10'd0);
        queue_item(apt_pkg::FUNC_SAMPLE, 10'd1023);
        queue_item(apt_pkg::FUNC_EXTEND, 10'd0);
        queue_item(apt_pkg::FUNC_SAMPLE, 10'd513);
        queue_item(apt_pkg::FUNC_SAMPLE, 10'd512);
        queue_item(apt_pkg::FUNC_SAMPLE, 10'd1023);
        queue_item(apt_pkg::FUNC_CONTRACT, 10'd0);
        queue_item(apt_pkg::FUNC_SAMPLE, 10'd0);
        queue_item(apt_pkg::FUNC_SAMPLE, 10'd1023);
        queue_item(apt_pkg::FUNC_SAMPLE, 10'd0);
        queue_item(apt_pkg::FUNC_CONTRACT, 10'd0);
        queue_item(apt_pkg::FUNC_STOP, 10'd1023);
        queue_item(apt_pkg::FUNC_SAMPLE, 10'd700);

        // every sample an edge, saturation at the top
        set_cfg(1'b1, 10'd512, 16'd1, 16'd0);
        queue_item(apt_pkg::FUNC_EXTEND, 10'd0);
        queue_item(apt_pkg::FUNC_SAMPLE, 10'd0);
        queue_item(apt_pkg::FUNC_SAMPLE, 10'd0);
        queue_item(apt_pkg::FUNC_EXTEND, 10'd0);

        // position above a lowered limit
        set_cfg(1'b1, 10'd512, 16'd0, 16'd0);
        queue_item(apt_pkg::FUNC_EXTEND, 10'd0);
        queue_item(apt_pkg::FUNC_SAMPLE, 10'd1023);
        queue_item(apt_pkg::FUNC_CONTRACT, 10'd0);
        queue_item(apt_pkg::FUNC_SAMPLE, 10'd0);

        // encoder off
        set_cfg(1'b0, 10'd512, 16'd0, 16'd0);
        queue_item(apt_pkg::FUNC_SAMPLE, 10'd1023);
        queue_item(apt_pkg::FUNC_EXTEND, 10'd0);
        queue_item(apt_pkg::FUNC_CONTRACT, 10'd0);
        queue_item(apt_pkg::FUNC_STOP, 10'd0);

        run_segment(1'b1, 10'd512,  16'd1000,  16'd100,   60, 33, 59);
        run_segment(1'b1, 10'd0,    16'd5,     16'd0,     45, 33, 59);
        run_segment(1'b1, 10'd1023, 16'd65535, 16'd2,     50, 33, 59);
        run_segment(1'b1, 10'd300,  16'd40,    16'd0,     80, 59, 33);
        run_segment(1'b1, 10'd700,  16'd3,     16'd1,     50, 59, 33);
        run_segment(1'b0, 10'd100,  16'd20,    16'd2,     50, 59, 33);
        run_segment(1'b1, 10'd1,    16'd0,     16'd65535, 40, 0, 0);
        run_segment(1'b1, 10'd511,  16'd65535, 16'd7,     55, 0, 0);
        run_segment(1'b1, 10'd900,  16'd12,    16'd4,     60, 0, 0);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
